[hdl/png_scanline_unfilter_core_macros.svh]
// Assertion macros for the checker file.
`ifndef PNG_SCANLINE_UNFILTER_CORE_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_CORE_MACROS_SVH

// Checked at every edge, reset included.
`define PSU_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only.
`define PSU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hdl/psu_pkg.sv]
package psu_pkg;

    localparam int ROW_BYTES_W   = 13;
    localparam int PIXEL_BYTES_W = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;

    localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = 13'd4;
    localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = 4'd4;

    localparam logic [7:0] FILTER_MAX = 8'd4;

    typedef enum logic [2:0] {
        F_NONE  = 3'd0,
        F_SUB   = 3'd1,
        F_UP    = 3'd2,
        F_AVG   = 3'd3,
        F_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_image;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       end_of_row;
        logic       bad_filter;
    } t_out_item;

endpackage

[hdl/psu_ram.sv]
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/psu_fifo.sv]
module psu_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hdl/psu_front.sv]
module psu_front #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  psu_pkg::t_in_item               i_in_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_job_push,
    output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)
                  + ((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)
                  + 15 - 1:0]               o_job,
    input  logic                            i_job_full
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int CL_W   = (LEN_W > psu_pkg::ROW_BYTES_W) ? LEN_W : psu_pkg::ROW_BYTES_W;
    localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int CB_W   = (BPP_W > psu_pkg::PIXEL_BYTES_W) ? BPP_W : psu_pkg::PIXEL_BYTES_W;
    localparam int CNT_W  = $clog2(COL_W + 1);

    typedef struct packed {
        logic [7:0]        data;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              left_ok;
        logic              first_row;
        psu_pkg::t_filter  filter;
        logic              bad;
        logic              last;
    } t_job;

    // S_CLAMP/S_DIV recompute the pixel slot of the current column after a register write
    typedef enum logic [1:0] {
        S_RUN,
        S_CLAMP,
        S_DIV
    } t_state;

    t_state                          r_state, n_state;
    logic [psu_pkg::ROW_BYTES_W-1:0]   r_row_bytes, n_row_bytes;
    logic [psu_pkg::PIXEL_BYTES_W-1:0] r_bpp, n_bpp;
    logic [COL_W-1:0]                r_column, n_column;
    logic [SLOT_W-1:0]               r_slot, n_slot;
    logic                            r_expect, n_expect;
    logic                            r_first_row, n_first_row;
    psu_pkg::t_filter                r_filter, n_filter;
    logic                            r_bad, n_bad;
    logic [COL_W-1:0]                r_div_num, n_div_num;
    logic [CB_W-1:0]                 r_rem, n_rem;
    logic [CNT_W-1:0]                r_cnt, n_cnt;

    logic [CL_W-1:0]   w_len;
    logic [CB_W-1:0]   w_bpp;
    logic [CL_W-1:0]   w_col_c;
    logic [COL_W-1:0]  w_col;
    logic              w_last;
    logic              w_acc;
    logic              w_type;
    logic [CB_W-1:0]   w_slot_p1;
    logic [CB_W:0]     w_rem_sh;
    logic [CB_W:0]     w_rem_nx;
    logic              w_bad_type;
    t_job              w_job;

    always_comb begin
        w_len = CL_W'(r_row_bytes);
        if (r_row_bytes == '0) begin
            w_len = CL_W'(1);
        end else if (w_len > CL_W'(MAX_ROW_BYTES)) begin
            w_len = CL_W'(MAX_ROW_BYTES);
        end
        w_bpp = CB_W'(r_bpp);
        if (r_bpp == '0) begin
            w_bpp = CB_W'(1);
        end else if (w_bpp > CB_W'(MAX_PIXEL_BYTES)) begin
            w_bpp = CB_W'(MAX_PIXEL_BYTES);
        end
    end

    assign w_col_c   = (CL_W'(r_column) >= w_len) ? w_len - CL_W'(1) : CL_W'(r_column);
    assign w_col     = w_col_c[COL_W-1:0];
    assign w_last    = (w_col_c + CL_W'(1)) >= w_len;
    assign w_slot_p1 = CB_W'(r_slot) + CB_W'(1);
    assign w_rem_sh  = {r_rem, r_div_num[COL_W-1]};
    assign w_rem_nx  = (w_rem_sh >= (CB_W + 1)'(w_bpp)) ? w_rem_sh - (CB_W + 1)'(w_bpp)
                                                      : w_rem_sh;
    assign w_bad_type = i_in_item.data_byte > psu_pkg::FILTER_MAX;

    assign full        = (r_state != S_RUN) || i_job_full;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = push && !full;
    assign w_type      = i_in_item.start_image || r_expect;

    always_comb begin
        w_job.data      = i_in_item.data_byte;
        w_job.col       = w_col;
        w_job.slot      = r_slot;
        w_job.left_ok   = w_col_c >= CL_W'(w_bpp);
        w_job.first_row = r_first_row;
        w_job.filter    = r_filter;
        w_job.bad       = r_bad;
        w_job.last      = w_last;
    end

    assign o_job_push = w_acc && !w_type;
    assign o_job      = w_job;

    always_comb begin
        n_state     = r_state;
        n_row_bytes = r_row_bytes;
        n_bpp       = r_bpp;
        n_column    = r_column;
        n_slot      = r_slot;
        n_expect    = r_expect;
        n_first_row = r_first_row;
        n_filter    = r_filter;
        n_bad       = r_bad;
        n_div_num   = r_div_num;
        n_rem       = r_rem;
        n_cnt       = r_cnt;

        if (w_acc) begin
            if (w_type) begin
                n_bad    = w_bad_type;
                n_filter = w_bad_type ? psu_pkg::F_NONE
                                      : psu_pkg::t_filter'(i_in_item.data_byte[2:0]);
                n_expect = 1'b0;
                n_column = '0;
                n_slot   = '0;
                if (i_in_item.start_image) begin
                    n_first_row = 1'b1;
                end
            end else if (w_last) begin
                n_column    = '0;
                n_slot      = '0;
                n_expect    = 1'b1;
                n_first_row = 1'b0;
            end else begin
                n_column = w_col + COL_W'(1);
                n_slot   = (w_slot_p1 == w_bpp) ? '0 : w_slot_p1[SLOT_W-1:0];
            end
        end

        unique case (r_state)
            S_RUN: begin
            end
            S_CLAMP: begin
                n_div_num = w_col;
                n_rem     = '0;
                n_cnt     = CNT_W'(COL_W);
                n_state   = S_DIV;
            end
            S_DIV: begin
                n_div_num = r_div_num << 1;
                n_rem     = w_rem_nx[CB_W-1:0];
                n_cnt     = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_slot  = w_rem_nx[SLOT_W-1:0];
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (i_cfg_valid) begin
            if (i_cfg_index == psu_pkg::CFG_ROW_BYTES) begin
                n_row_bytes = i_cfg_data[psu_pkg::ROW_BYTES_W-1:0];
            end else if (i_cfg_index == psu_pkg::CFG_PIXEL_BYTES) begin
                n_bpp = i_cfg_data[psu_pkg::PIXEL_BYTES_W-1:0];
            end
            n_state = S_CLAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_row_bytes <= psu_pkg::ROW_BYTES_RST;
            r_bpp       <= psu_pkg::PIXEL_BYTES_RST;
            r_column    <= '0;
            r_slot      <= '0;
            r_expect    <= 1'b1;
            r_first_row <= 1'b1;
            r_filter    <= psu_pkg::F_NONE;
            r_bad       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_row_bytes <= n_row_bytes;
            r_bpp       <= n_bpp;
            r_column    <= n_column;
            r_slot      <= n_slot;
            r_expect    <= n_expect;
            r_first_row <= n_first_row;
            r_filter    <= n_filter;
            r_bad       <= n_bad;
            r_cnt       <= n_cnt;
        end
        r_div_num <= n_div_num;
        r_rem     <= n_rem;
    end

endmodule

[hdl/psu_back.sv]
module psu_back #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_empty,
    output logic                 o_job_pop,
    input  logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)
                  + ((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)
                  + 15 - 1:0]    i_job,
    output logic                 o_res_push,
    output psu_pkg::t_out_item   o_res,
    input  logic                 i_res_full
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    typedef struct packed {
        logic [7:0]        data;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              left_ok;
        logic              first_row;
        psu_pkg::t_filter  filter;
        logic              bad;
        logic              last;
    } t_job;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] d_bc;
        logic signed [10:0] d_ac;
        logic signed [10:0] d_sum;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        d_bc  = $signed({3'b000, b}) - $signed({3'b000, c});
        d_ac  = $signed({3'b000, a}) - $signed({3'b000, c});
        d_sum = d_bc + d_ac;
        pa    = (d_bc < 0) ? 11'(-d_bc) : 11'(d_bc);
        pb    = (d_ac < 0) ? 11'(-d_ac) : 11'(d_ac);
        pc    = (d_sum < 0) ? 11'(-d_sum) : 11'(d_sum);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    t_job              w_head;
    t_job              r_job;
    logic              r_vld;
    logic              r_fwd;
    logic [7:0]        r_fwd_data;
    logic [7:0]        r_lh  [MAX_PIXEL_BYTES];
    logic [7:0]        r_alh [MAX_PIXEL_BYTES];
    logic [7:0]        w_ram_q;
    logic              w_fire;
    logic              w_pop;
    logic [7:0]        w_a;
    logic [7:0]        w_b;
    logic [7:0]        w_c;
    logic [8:0]        w_sum;
    logic [7:0]        w_pred;
    logic [7:0]        w_val;

    assign w_head    = i_job;
    assign w_fire    = r_vld && !i_res_full;
    assign w_pop     = !i_job_empty && (!r_vld || w_fire);
    assign o_job_pop = w_pop;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_job.col),
        .i_wdata (w_val),
        .i_re    (w_pop),
        .i_raddr (w_head.col),
        .o_rdata (w_ram_q)
    );

    always_comb begin
        w_a   = r_job.left_ok ? r_lh[r_job.slot] : 8'd0;
        w_b   = r_job.first_row ? 8'd0 : (r_fwd ? r_fwd_data : w_ram_q);
        w_c   = (r_job.first_row || !r_job.left_ok) ? 8'd0 : r_alh[r_job.slot];
        w_sum = {1'b0, w_a} + {1'b0, w_b};
        unique case (r_job.filter)
            psu_pkg::F_NONE:  w_pred = 8'd0;
            psu_pkg::F_SUB:   w_pred = w_a;
            psu_pkg::F_UP:    w_pred = w_b;
            psu_pkg::F_AVG:   w_pred = w_sum[8:1];
            psu_pkg::F_PAETH: w_pred = paeth(w_a, w_b, w_c);
            default:          w_pred = 8'd0;
        endcase
        w_val = r_job.bad ? r_job.data : r_job.data + w_pred;
    end

    always_comb begin
        o_res.pixel_byte = w_val;
        o_res.end_of_row = r_job.last;
        o_res.bad_filter = r_job.bad;
    end
    assign o_res_push = w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_fwd <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_lh[SLOT_W'(i)]  <= 8'd0;
                r_alh[SLOT_W'(i)] <= 8'd0;
            end
        end else begin
            if (w_pop) begin
                r_vld <= 1'b1;
                // line buffer read-first: bypass a write to the same column
                r_fwd <= w_fire && (w_head.col == r_job.col);
            end else if (w_fire) begin
                r_vld <= 1'b0;
            end
            if (w_fire) begin
                r_lh[r_job.slot]  <= w_val;
                r_alh[r_job.slot] <= w_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job      <= w_head;
            r_fwd_data <= w_val;
        end
    end

endmodule

[hdl/png_scanline_unfilter_core.sv]
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------------
// input     | push / full             | i_in_item: data_byte, start_image
// result    | empty / pop             | o_out_item: pixel_byte, end_of_row, bad_filter
// config    | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while full stays low; an accepted item passes through the job queue,
// the reconstruct register and the result queue before its result is on the result ports.
// The left-neighbour history is registered and feeds back through the reconstruct stage.
// A register write holds full through the pixel slot recompute (states S_CLAMP and S_DIV).
// Synchronous active-low reset; the line buffer is not cleared.
// A stalled result side backs up through two-entry queues before full rises.
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  psu_pkg::t_in_item               i_in_item,
    output logic                            empty,
    input  logic                            pop,
    output psu_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int JOB_W  = COL_W + SLOT_W + 15;

    typedef logic [JOB_W-1:0] t_job_bits;

    logic               w_job_push;
    logic               w_job_full;
    logic               w_job_pop;
    logic               w_job_empty;
    t_job_bits          w_job_in;
    t_job_bits          w_job_out;
    logic               w_res_push;
    logic               w_res_full;
    psu_pkg::t_out_item w_res;

    psu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .i_job_full  (w_job_full)
    );

    psu_fifo #(
        .t_data (t_job_bits),
        .DEPTH  (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_job       (w_job_out),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    psu_fifo #(
        .t_data (psu_pkg::t_out_item),
        .DEPTH  (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

[hdl/psu_checker.sv]
`include "png_scanline_unfilter_core_macros.svh"

module psu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input psu_pkg::t_out_item o_out_item,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready
);

    // both queues clear and the slot recompute is dropped by reset
    `PSU_ASSERT(a_reset_idle, i_clk, !i_rst_n |=> (empty && !full), "not idle after reset")

    `PSU_ASSERT_RST(a_result_held, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_item)), "waiting result changed")

    // a register write blocks input for at least the clamp and one divide step
    `PSU_ASSERT_RST(a_cfg_blocks, i_clk, i_rst_n, (i_cfg_valid && o_cfg_ready) |=> (full ##1 full), "input open during slot recompute")

    `PSU_ASSERT_RST(a_cfg_ready, i_clk, i_rst_n, (push && !full) |-> o_cfg_ready, "config port not ready")

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_item  (o_out_item),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
